### src/pfact_pkg.sv
package pfact_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_RESULTS    = 30;
    localparam int COUNT_BITS     = $clog2(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_LOOP,
        ST_DIV,
        ST_JUDGE,
        ST_FINISH
    } pfact_state_t;

    typedef enum logic [1:0] {
        EMIT_PEND,
        EMIT_REST,
        EMIT_EMPTY
    } pfact_emit_t;

    // controller -> datapath
    typedef struct packed {
        logic        load;         // take a new item
        logic        div_start;    // start rest / divisor
        logic        take_factor;  // divisor divides: pend <= d, rest <= quotient
        logic        next_div;     // advance to next trial divisor
        logic        clr_pend;     // pending factor has been sent
        logic        emit;         // write output register
        pfact_emit_t emit_sel;
        logic        emit_last;
    } pfact_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_small;     // incoming value <= 1
        logic sq_le_rest;   // d*d <= rest
        logic div_busy;
        logic rem_zero;
        logic at_limit;     // result count reached MAX_RESULTS-1
        logic pend_valid;
        logic rest_gt1;
        logic out_free;
    } pfact_status_t;

endpackage

### src/prime_factorization.sv
// Trial-division factorizer. Each trial divisor costs one bit-serial division
// plus the loop and judge states, so the worst case grows with sqrt(value) and
// falls on a large prime; an input of 0 or 1 skips the search (empty result).
// Throughput: one item at a time; the next item is taken once the last result
// is in the output register. The bit-serial divider sets the rate.
// Reset: rst_n asynchronous, active low; returns to idle with no result pending.
module prime_factorization #(
    parameter int VALUE_BITS = pfact_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] factor,
    output logic                  last,
    output logic                  empty_res
);
    import pfact_pkg::*;

    // The controller walks trial divisors d = 2, 3, ... while d*d <= rest.
    // For each it runs the serial divider on rest / d; a zero remainder
    // records d as a factor and divides again with the same d.
    // A found factor is held in a pending register until the next one is
    // known, so the final item can carry last without a second pass.
    // The datapath owns the output register, so a waiting result never
    // blocks the search beyond the cycle that needs to write it.

    pfact_cmd_t    cmd;
    pfact_status_t st;

    pfact_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pfact_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .factor    (factor),
        .last      (last),
        .empty_res (empty_res)
    );

endmodule

### src/pfact_ctrl.sv
module pfact_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pfact_pkg::pfact_status_t st,
    output pfact_pkg::pfact_cmd_t    cmd
);
    import pfact_pkg::*;

    pfact_state_t state_reg;
    pfact_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.in_small ? ST_EMPTY : ST_LOOP;
                end
            end
            ST_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_EMPTY;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LOOP:
            begin
                if (st.sq_le_rest)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (st.rem_zero)
                begin
                    if (st.at_limit)
                    begin
                        // the undivided rest closes the list unfactored
                        state_next = ST_FINISH;
                    end
                    else if (!st.pend_valid || st.out_free)
                    begin
                        if (st.pend_valid)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_PEND;
                        end
                        cmd.take_factor = 1'b1;
                        cmd.div_start   = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_LOOP;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.pend_valid)
                    begin
                        cmd.emit_sel  = EMIT_PEND;
                        cmd.emit_last = !st.rest_gt1;
                        cmd.clr_pend  = 1'b1;
                        if (!st.rest_gt1)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.emit_sel  = EMIT_REST;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/pfact_dp.sv
module pfact_dp #(
    parameter int VALUE_BITS = pfact_pkg::VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [VALUE_BITS-1:0]    value,
    input  pfact_pkg::pfact_cmd_t    cmd,
    output pfact_pkg::pfact_status_t st,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VALUE_BITS-1:0]    factor,
    output logic                     last,
    output logic                     empty_res
);
    import pfact_pkg::*;

    localparam int VB       = VALUE_BITS;
    localparam int CNT_BITS = $clog2(VB + 1);

    logic [VB-1:0]         rest_reg;
    logic [VB-1:0]         d_reg;
    logic [VB:0]           sq_reg;       // d*d, kept by increments
    logic [VB-1:0]         pend_reg;
    logic                  pend_valid_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // restoring divider, one quotient bit per cycle
    logic [VB-1:0]         quo_reg;
    logic [VB-1:0]         rem_reg;
    logic [CNT_BITS-1:0]   dcnt_reg;
    logic                  busy_reg;

    logic                  out_valid_reg;
    logic [VB-1:0]         factor_reg;
    logic                  last_reg;
    logic                  empty_reg;

    logic [VB:0]           shl;
    logic [VB+1:0]         diff;
    logic                  borrow;
    logic                  out_free;

    assign shl    = {rem_reg, quo_reg[VB-1]};
    assign diff   = {1'b0, shl} - {2'b00, d_reg};
    assign borrow = diff[VB+1];

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st.in_small   = (value <= VB'(1));
        st.sq_le_rest = (sq_reg <= {1'b0, rest_reg});
        st.div_busy   = busy_reg;
        st.rem_zero   = (rem_reg == '0);
        st.at_limit   = (count_reg == COUNT_BITS'(MAX_RESULTS - 1));
        st.pend_valid = pend_valid_reg;
        st.rest_gt1   = (rest_reg > VB'(1));
        st.out_free   = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && dcnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end

            if (cmd.load || cmd.clr_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.take_factor)
            begin
                pend_valid_reg <= 1'b1;
            end

            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (cmd.take_factor)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rest_reg <= value;
            d_reg    <= VB'(2);
            sq_reg   <= (VB + 1)'(4);
        end
        else
        begin
            if (cmd.take_factor)
            begin
                rest_reg <= quo_reg;
                pend_reg <= d_reg;
            end
            if (cmd.next_div)
            begin
                d_reg  <= d_reg + VB'(1);
                sq_reg <= sq_reg + {d_reg, 1'b1};
            end
        end

        if (cmd.div_start)
        begin
            quo_reg  <= cmd.take_factor ? quo_reg : rest_reg;
            rem_reg  <= '0;
            dcnt_reg <= CNT_BITS'(VB);
        end
        else if (busy_reg)
        begin
            quo_reg  <= {quo_reg[VB-2:0], !borrow};
            rem_reg  <= borrow ? shl[VB-1:0] : diff[VB-1:0];
            dcnt_reg <= dcnt_reg - CNT_BITS'(1);
        end

        if (cmd.emit)
        begin
            case (cmd.emit_sel)
                EMIT_PEND:  factor_reg <= pend_reg;
                EMIT_REST:  factor_reg <= rest_reg;
                EMIT_EMPTY: factor_reg <= '0;
                default:    factor_reg <= '0;
            endcase
            last_reg  <= cmd.emit_last;
            empty_reg <= (cmd.emit_sel == EMIT_EMPTY);
        end
    end

    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;

endmodule

### dv/prime_factorization_tb.sv
module prime_factorization_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pfact_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 1;

    // One factor as it leaves the block.
    typedef struct {
        logic [VB-1:0] factor;
        logic          last;
        logic          empty_res;
    } factor_res_t;

    // One value waiting to be offered. hold_for_drain makes the sender
    // wait until every factor owed so far has come back.
    typedef struct {
        logic [VB-1:0] value;
        bit            hold_for_drain;
    } factor_job_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [VB-1:0] value = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [VB-1:0] factor;
    logic          last;
    logic          empty_res;

    factor_job_t jobs_to_send[$];
    factor_res_t factors_due[$];

    int values_taken = 0;   // items accepted by the block
    int factors_seen = 0;   // results accepted from the block
    int mismatches   = 0;
    int stall_left   = 0;   // long receiver hold-off, in cycles
    bit stall_done   = 1'b0;

    prime_factorization #(
        .VALUE_BITS(VB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .factor    (factor),
        .last      (last),
        .empty_res (empty_res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Trial division, same order and result limit as the block:
    // divisors rise while d*d <= rest, each divisor is sent as often
    // as it divides; a leftover rest above one closes the list, otherwise
    // the last divisor sent carries the last flag. Zero and one get a
    // single empty result.
    function automatic void push_factor_list(input logic [VB-1:0] v);
        longint unsigned rest;
        longint unsigned d;
        factor_res_t     list[$];
        factor_res_t     r;
        bit              closed;
        rest   = 64'(v);
        closed = 1'b0;
        if (rest <= 1)
        begin
            r = '{factor: '0, last: 1'b1, empty_res: 1'b1};
            factors_due.push_back(r);
            return;
        end
        d = 2;
        while (!closed && d <= rest / d)
        begin
            while (!closed && rest % d == 0)
            begin
                if (list.size() == MAX_RESULTS - 1)
                begin
                    // result limit: the undivided rest itself ends the list
                    r = '{factor: rest[VB-1:0], last: 1'b1, empty_res: 1'b0};
                    list.push_back(r);
                    closed = 1'b1;
                end
                else
                begin
                    r = '{factor: d[VB-1:0], last: 1'b0, empty_res: 1'b0};
                    list.push_back(r);
                    rest = rest / d;
                end
            end
            d++;
        end
        if (!closed)
        begin
            if (rest > 1)
            begin
                r = '{factor: rest[VB-1:0], last: 1'b1, empty_res: 1'b0};
                list.push_back(r);
            end
            else
            begin
                list[list.size() - 1].last = 1'b1;
            end
        end
        foreach (list[i]) factors_due.push_back(list[i]);
    endfunction

    // Random values are kept cheap for a trial divider: the run time grows
    // with the second largest prime factor and the root of the largest, so they
    // are built from small numbers, with a moderate cofactor now and then.
    function automatic logic [VB-1:0] pick_value();
        longint unsigned v;
        longint unsigned f;
        int              mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            v = 64'($urandom) & ((64'd1 << $urandom_range(1, 16)) - 1);
        end
        else if (mode < 8)
        begin
            // product of small numbers, usually climbing into the top bits
            v = 1;
            repeat ($urandom_range(1, 12))
            begin
                f = $urandom_range(2, 300);
                if (v * f <= VALUE_MAX) v = v * f;
            end
        end
        else
        begin
            v = 64'($urandom_range(1, 1000)) * 64'($urandom_range(2, 200000));
        end
        return v[VB-1:0];
    endfunction

    function automatic void add_job(input longint unsigned v, input bit drain);
        factor_job_t j;
        j.value          = v[VB-1:0];
        j.hold_for_drain = drain;
        jobs_to_send.push_back(j);
    endfunction

    // Sender: keeps valid and value steady until the handshake, idles about
    // a quarter of the time except in a calm window of accepted items.
    always @(posedge clk or negedge rst_n)
    begin
        bit calm;
        bit idle;
        bit draining;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                push_factor_list(value);
                values_taken++;
            end
            if (!in_valid || in_ready)
            begin
                calm     = (values_taken >= 30 && values_taken < 55);
                idle     = !calm && ($urandom_range(0, 99) < 26);
                draining = jobs_to_send.size() > 0 && jobs_to_send[0].hold_for_drain &&
                           factors_due.size() > 0;
                if (jobs_to_send.size() > 0 && !idle && !draining)
                begin
                    in_valid <= 1'b1;
                    value    <= jobs_to_send[0].value;
                    jobs_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, a calm window of results, and one long
    // hold-off while the sender keeps offering so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!stall_done && values_taken >= 12)
        begin
            stall_done <= 1'b1;
            stall_left <= 400;
            out_ready  <= 1'b0;
        end
        else if (factors_seen >= 70 && factors_seen < 130)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    // Checker: each accepted factor against the oldest one owed.
    always @(posedge clk)
    begin
        factor_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            factors_seen++;
            if (factors_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected result factor=%0d last=%0b empty=%0b",
                             $realtime, factor, last, empty_res);
            end
            else
            begin
                want = factors_due.pop_front();
                if (factor !== want.factor || last !== want.last ||
                    empty_res !== want.empty_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "%t: factor %0d/%0d last %0b/%0b empty %0b/%0b (expected/actual)",
                            $realtime, want.factor, factor, want.last, last,
                            want.empty_res, empty_res);
                end
            end
        end
    end

    initial
    begin
        // Directed part: empty cases, tiny values, divisor closing the
        // list vs. leftover prime, the thirty-factor limit, top-bit values
        // and the largest prime the field holds (d*d passes 2^31 there).
        add_job(1, 1'b0);
        add_job(0, 1'b0);
        add_job(2, 1'b0);
        add_job(3, 1'b0);
        add_job(4, 1'b0);
        add_job(8, 1'b0);
        add_job(12, 1'b0);
        add_job(49, 1'b0);
        add_job(97, 1'b0);
        add_job(65521, 1'b0);
        add_job(64'd1 << 30, 1'b0);
        add_job((64'd1 << 30) + 1, 1'b0);
        add_job(VALUE_MAX - 1, 1'b0);
        add_job(64'd1162261467, 1'b0);
        add_job(64'd1 << 29, 1'b0);
        add_job(64'd2 * 3 * 5 * 7 * 11 * 13 * 17 * 19 * 23, 1'b0);
        add_job(VALUE_MAX, 1'b0);
        add_job(1, 1'b1);
        // Random part; one item waits for a full drain midway.
        for (int i = 0; i < 90; i++)
            add_job(64'(pick_value()), (i == 45));

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (jobs_to_send.size() != 0 || in_valid || factors_due.size() != 0);
        // Keep running so that a stray result would still show up.
        repeat (50) @(posedge clk);

        if (mismatches == 0 && factors_due.size() == 0)
            $display("** prime_factorization: PASSED **");
        else
            $display("** prime_factorization: FAILED **");
        $finish;
    end

    // Watchdog: the largest prime is the longest single item; the limit allows
    // several times the expected run of the whole test.
    initial
    begin
        #100_000_000;
        $display("** prime_factorization: FAILED **");
        $finish;
    end

endmodule

### filelist.f
src/pfact_pkg.sv
src/pfact_ctrl.sv
src/pfact_dp.sv
src/prime_factorization.sv
dv/prime_factorization_tb.sv
